FILE: rtl/core/xmcr_pkg.sv
// Shared types and constants of the XMODEM CRC receiver.
package xmcr_pkg;

  localparam logic [7:0] ChSoh = 8'h01;
  localparam logic [7:0] ChEot = 8'h04;
  localparam logic [7:0] ChAck = 8'h06;
  localparam logic [7:0] ChNak = 8'h15;
  localparam logic [7:0] ChCan = 8'h18;
  localparam logic [7:0] ChC   = 8'h43;

  localparam logic [15:0] CrcPoly = 16'h1021;

  typedef enum logic [1:0] {
    CmdStart = 2'd0,
    CmdByte  = 2'd1,
    CmdTick  = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhWait  = 3'd1,
    PhCan2  = 3'd2,
    PhRecv  = 3'd3,
    PhFlush = 3'd4,
    PhDone  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ActNone     = 3'd0,
    ActComplete = 3'd2,
    ActRcancel  = 3'd3,
    ActSync     = 3'd4,
    ActRetry    = 3'd5
  } act_e;

  typedef enum logic [1:0] {
    RegByteTimeout = 2'd0,
    RegFlushQuiet  = 2'd1,
    RegRetryLimit  = 2'd2,
    RegUnused      = 2'd3
  } reg_e;

  // Emission sequencer states
  typedef enum logic [2:0] {
    EmIdle  = 3'd0,
    EmCrc   = 3'd1,
    EmWords = 3'd2,
    EmTx    = 3'd3,
    EmWait  = 3'd4
  } emit_e;

  // Control from the protocol FSM to the CRC unit
  typedef struct packed {
    logic       start;
    logic       clear;
    logic [7:0] data;
  } crc_ctl_t;

endpackage

FILE: rtl/core/xmcr_crc.sv
// Bit-serial CRC-16 (poly 0x1021) unit, one bit per cycle.
module xmcr_crc
  import xmcr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  crc_ctl_t ctl_i,
  output logic     busy_o,
  output logic [15:0] crc_o
);

  logic [15:0] crc_q, crc_d;
  logic [7:0]  sh_q, sh_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        fb;

  assign fb     = crc_q[15] ^ sh_q[7];
  assign busy_o = (cnt_q != 4'd0);
  assign crc_o  = crc_q;

  // Shift one message bit per cycle into the register
  always_comb begin
    crc_d = crc_q;
    sh_d  = sh_q;
    cnt_d = cnt_q;
    if (ctl_i.clear) begin
      crc_d = 16'h0000;
      cnt_d = 4'd0;
    end else if (ctl_i.start) begin
      sh_d  = ctl_i.data;
      cnt_d = 4'd8;
    end else if (cnt_q != 4'd0) begin
      crc_d = {crc_q[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
      sh_d  = {sh_q[6:0], 1'b0};
      cnt_d = cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= 16'h0000;
      cnt_q <= 4'd0;
      sh_q  <= 8'h00;
    end else begin
      crc_q <= crc_d;
      cnt_q <= cnt_d;
      sh_q  <= sh_d;
    end
  end

endmodule

FILE: rtl/core/xmodem_crc_receiver.sv
// Top level of the XMODEM CRC receiver: protocol FSM, packet store, emission.
//
// Usage: s_axis carries one command per transaction (start, received byte,
// tick); tuser holds the command and tdata the line byte. Every command
// produces zero or more result transactions on m_axis, the final one of the
// command marked by tlast. tdata carries the payload word, tx byte, status
// and byte total; tuser carries tx_valid and data_valid.
// A packet data byte is shifted bit-serially through the CRC unit, so the
// next command is taken only once the CRC unit is idle again. A good new
// packet is read from the packet store byte by byte (address, then
// registered data) and emitted as PACKET_BYTES/4 words.
// Results are held in an output register; while m_axis_tready is low the
// block holds the result and takes no further command. Configuration writes
// are taken at any time on cfg_valid_i/cfg_ready_o.
// Reset puts the block idle with register defaults (timeout 1000, flush 100,
// retry limit 16); the packet store is not cleared and needs no clearing.
module xmodem_crc_receiver
  import xmcr_pkg::*;
#(
  parameter int PACKET_BYTES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cfg port
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [7:0] tx_byte, [39:8] data_word,
                                      // [42:40] status, [74:43] total_bytes, pad
  output logic [1:0]  m_axis_tuser,   // [0] tx_valid, [1] data_valid
  output logic        m_axis_tlast
);

  localparam int Depth = PACKET_BYTES + 4;
  localparam int Aw    = $clog2(Depth);
  localparam int Bw    = $clog2(Depth + 2);
  localparam int Words = PACKET_BYTES / 4;
  localparam int Ww    = $clog2(Words + 1);
  localparam logic [31:0] PktBytes32 = 32'(PACKET_BYTES);

  // config registers
  logic [15:0] tmo_q, flq_q;
  logic [7:0]  rlim_q;

  // protocol state
  phase_e      phase_q, phase_d;
  logic [7:0]  exp_q, exp_d;
  logic [7:0]  ret_q, ret_d;
  logic        crcm_q, crcm_d;
  logic [7:0]  pend_q, pend_d;
  logic [Bw-1:0] idx_q, idx_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] tick_q, tick_d;
  act_e        act_q, act_d;
  logic [31:0] total_q, total_d;

  // header / trailer captures
  logic [7:0]  seq_q, seq_d, nseq_q, nseq_d, ck0_q, ck0_d, ck1_q, ck1_d;

  // sequencer
  emit_e       em_q, em_d;
  logic [1:0]  ntx_q, ntx_d;     // tx results still to send
  logic [7:0]  txb_q, txb_d;
  logic        words_q, words_d; // emit words before tx
  logic [Ww-1:0] wcnt_q, wcnt_d;
  logic [1:0]  bsel_q, bsel_d;
  logic [Aw-1:0] rd_q, rd_d;
  logic [31:0] word_q, word_d;
  logic        rdv_q;

  // output register
  logic        ov_q, ov_d;
  logic [7:0]  otx_q, otx_d;
  logic [31:0] ow_q, ow_d;
  logic        otv_q, otv_d, odv_q, odv_d, olast_q, olast_d;

  // memory
  logic [7:0]  mem [Depth];
  logic [7:0]  rdata_q;
  logic        we;
  logic [Aw-1:0] waddr;

  crc_ctl_t    cctl;
  logic        cbusy;
  logic [15:0] crc;

  logic        acc;
  cmd_e        cmd;
  logic [7:0]  b;
  logic [2:0]  status;
  logic [Bw-1:0] pos;
  logic [15:0] tick_inc;

  xmcr_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cctl),
    .busy_o (cbusy),
    .crc_o  (crc)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (em_q == EmIdle) && !ov_q && !cbusy;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser);
  assign b             = s_axis_tdata;
  assign pos           = idx_q - Bw'(1);
  assign tick_inc      = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;

  always_comb begin
    unique case (phase_q)
      PhIdle:  status = 3'd0;
      PhDone:  status = act_q;
      default: status = 3'd1;
    endcase
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {5'd0, total_q, status, ow_q, otx_q};
  assign m_axis_tuser  = {odv_q, otv_q};
  assign m_axis_tlast  = olast_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q  <= 16'd1000;
      flq_q  <= 16'd100;
      rlim_q <= 8'd16;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        RegByteTimeout: tmo_q  <= cfg_data_i;
        RegFlushQuiet:  flq_q  <= cfg_data_i;
        RegRetryLimit:  rlim_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Packet store: one write, one registered read
  assign we    = acc && (cmd == CmdByte) && (phase_q == PhRecv) && (pos < Bw'(Depth));
  assign waddr = pos[Aw-1:0];
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= b;
    rdata_q <= mem[rd_q];
  end

  // Protocol state and sequencer
  always_comb begin
    logic ok;
    logic [Bw-1:0] nidx;
    ok = 1'b0;
    nidx = '0;
    phase_d = phase_q; exp_d = exp_q; ret_d = ret_q; crcm_d = crcm_q;
    pend_d = pend_q; idx_d = idx_q; sum_d = sum_q; tick_d = tick_q;
    act_d = act_q; total_d = total_q;
    seq_d = seq_q; nseq_d = nseq_q; ck0_d = ck0_q; ck1_d = ck1_q;
    em_d = em_q; ntx_d = ntx_q; txb_d = txb_q; words_d = words_q;
    wcnt_d = wcnt_q; bsel_d = bsel_q; rd_d = rd_q; word_d = word_q;
    ov_d = ov_q; otx_d = otx_q; ow_d = ow_q; otv_d = otv_q; odv_d = odv_q;
    olast_d = olast_q;
    cctl = '{start: 1'b0, clear: 1'b0, data: b};

    if (ov_q && m_axis_tready) ov_d = 1'b0;

    if (acc) begin
      unique case (cmd)
        CmdStart: begin
          exp_d = 8'd1; ret_d = rlim_q; crcm_d = 1'b0; pend_d = ChC;
          idx_d = '0; sum_d = '0; tick_d = '0; act_d = ActNone;
          total_d = '0; cctl.clear = 1'b1;
          if (rlim_q == 8'd0) begin
            phase_d = PhFlush; act_d = ActRetry;
          end else begin
            phase_d = PhWait; em_d = EmTx; ntx_d = 2'd1; txb_d = ChC;
            words_d = 1'b0;
          end
        end
        CmdByte: begin
          priority case (1'b1)
            (phase_q == PhWait || phase_q == PhCan2): begin
              if (phase_q == PhWait && b == ChEot) begin
                phase_d = PhFlush; act_d = ActComplete; tick_d = '0;
              end else if (b == ChCan && phase_q == PhWait) begin
                phase_d = PhCan2; tick_d = '0;
              end else if (b == ChCan) begin
                phase_d = PhFlush; act_d = ActRcancel; tick_d = '0;
              end else begin
                if (pend_q == ChC) crcm_d = 1'b1;
                idx_d = Bw'(1); sum_d = '0; tick_d = '0; phase_d = PhRecv;
                cctl.clear = 1'b1;
              end
            end
            (phase_q == PhRecv): begin
              if (pos == Bw'(0)) seq_d = b;
              if (pos == Bw'(1)) nseq_d = b;
              if (pos == Bw'(PACKET_BYTES + 2)) ck0_d = b;
              if (pos == Bw'(PACKET_BYTES + 3)) ck1_d = b;
              if (pos >= Bw'(2) && pos < Bw'(PACKET_BYTES + 2)) begin
                sum_d = sum_q + b;
                cctl.start = 1'b1;
              end
              nidx = idx_q + Bw'(1);
              idx_d = nidx; tick_d = '0;
              if (nidx >= Bw'(Depth) + Bw'(crcm_q)) em_d = EmCrc;
            end
            (phase_q == PhFlush): tick_d = '0;
            default: ;
          endcase
        end
        CmdTick: begin
          if (phase_q == PhWait || phase_q == PhCan2 || phase_q == PhRecv) begin
            tick_d = tick_inc;
            if (tick_inc >= tmo_q) begin
              if (phase_q == PhWait) begin
                if (ret_q != 8'd0) begin
                  ret_d = ret_q - 8'd1;
                end
                if (ret_q <= 8'd1) begin
                  phase_d = PhFlush; act_d = ActRetry; tick_d = '0;
                end else begin
                  em_d = EmTx; ntx_d = 2'd1; txb_d = pend_q; words_d = 1'b0;
                  tick_d = '0;
                end
              end else if (phase_q == PhCan2) begin
                if (pend_q == ChC) crcm_d = 1'b1;
                idx_d = Bw'(1); sum_d = '0; tick_d = '0; phase_d = PhRecv;
                cctl.clear = 1'b1;
              end else begin
                if (ret_q != 8'd0) ret_d = ret_q - 8'd1;
                pend_d = ChNak; phase_d = PhFlush; act_d = ActNone; tick_d = '0;
              end
            end
          end else if (phase_q == PhFlush) begin
            tick_d = tick_inc;
            if (tick_inc >= flq_q) begin
              if (act_q == ActComplete || act_q == ActRcancel) begin
                em_d = EmTx; ntx_d = 2'd1; txb_d = ChAck; words_d = 1'b0;
                phase_d = PhDone;
              end else if (act_q == ActSync || act_q == ActRetry) begin
                em_d = EmTx; ntx_d = 2'd3; txb_d = ChCan; words_d = 1'b0;
                phase_d = PhDone;
              end else if (ret_q == 8'd0) begin
                act_d = ActRetry; tick_d = '0;
              end else begin
                em_d = EmTx; ntx_d = 2'd1; txb_d = pend_q; words_d = 1'b0;
                phase_d = PhWait; tick_d = '0;
              end
            end
          end
        end
        default: ;
      endcase
    end

    unique case (em_q)
      EmCrc: begin
        // Wait for the last CRC bits, then judge the packet
        if (!cbusy) begin
          ok = (seq_q == ~nseq_q) &&
               (crcm_q ? (crc == {ck0_q, ck1_q}) : (sum_q == ck0_q));
          if (!ok) begin
            if (ret_q != 8'd0) ret_d = ret_q - 8'd1;
            pend_d = ChNak; phase_d = PhFlush; act_d = ActNone; tick_d = '0;
            em_d = EmIdle;
          end else if (seq_q == exp_q || seq_q == exp_q - 8'd1) begin
            pend_d = ChAck;
            words_d = (seq_q == exp_q);
            if (seq_q == exp_q) begin
              total_d = (32'hFFFF_FFFF - total_q < PktBytes32) ? 32'hFFFF_FFFF
                                                                : total_q + PktBytes32;
              exp_d = exp_q + 8'd1;
              ret_d = rlim_q;
            end
            // loop_top with the updated retry count
            if ((seq_q == exp_q ? rlim_q : ret_q) == 8'd0) begin
              ntx_d = 2'd0; phase_d = PhFlush; act_d = ActRetry;
            end else begin
              ntx_d = 2'd1; txb_d = ChAck; phase_d = PhWait;
            end
            tick_d = '0;
            wcnt_d = '0; bsel_d = '0; rd_d = Aw'(2);
            em_d = (seq_q == exp_q) ? EmWords : ((seq_q == exp_q ? rlim_q : ret_q) == 8'd0
                                                 ? EmIdle : EmTx);
          end else begin
            phase_d = PhFlush; act_d = ActSync; tick_d = '0; em_d = EmIdle;
          end
        end
      end
      EmWords: begin
        // Gather four bytes per word from the store, one read at a time
        if (!ov_q || m_axis_tready) begin
          if (rdv_q) begin
            word_d = {rdata_q, word_q[31:8]};
            bsel_d = bsel_q + 2'd1;
            if (bsel_q == 2'd3) begin
              ov_d = 1'b1; otv_d = 1'b0; otx_d = '0; odv_d = 1'b1;
              ow_d = {rdata_q, word_q[31:8]};
              wcnt_d = wcnt_q + Ww'(1);
              olast_d = (wcnt_q == Ww'(Words - 1)) && (ntx_q == 2'd0);
              if (wcnt_q == Ww'(Words - 1))
                em_d = (ntx_q == 2'd0) ? EmIdle : EmTx;
            end
            if (rd_q != Aw'(Depth - 1)) rd_d = rd_q + Aw'(1);
          end
        end
      end
      EmTx: begin
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1; otv_d = 1'b1; otx_d = txb_q; odv_d = 1'b0; ow_d = '0;
          olast_d = (ntx_q == 2'd1);
          ntx_d = ntx_q - 2'd1;
          if (ntx_q == 2'd1) em_d = EmIdle;
        end
      end
      default: ;
    endcase
  end

  // The read of each byte is valid in the cycle after its address was issued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rdv_q <= 1'b0;
    else rdv_q <= (em_q == EmWords) && !(rdv_q && !(!ov_q || m_axis_tready))
                  && !(rdv_q && (!ov_q || m_axis_tready));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle; exp_q <= 8'd1; ret_q <= '0; crcm_q <= 1'b0;
      pend_q <= ChC; idx_q <= '0; sum_q <= '0; tick_q <= '0;
      act_q <= ActNone; total_q <= '0; em_q <= EmIdle; ntx_q <= '0;
      ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d; exp_q <= exp_d; ret_q <= ret_d; crcm_q <= crcm_d;
      pend_q <= pend_d; idx_q <= idx_d; sum_q <= sum_d; tick_q <= tick_d;
      act_q <= act_d; total_q <= total_d; em_q <= em_d; ntx_q <= ntx_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q <= seq_d; nseq_q <= nseq_d; ck0_q <= ck0_d; ck1_q <= ck1_d;
    txb_q <= txb_d; words_q <= words_d; wcnt_q <= wcnt_d; bsel_q <= bsel_d;
    rd_q <= rd_d; word_q <= word_d;
    otx_q <= otx_d; ow_q <= ow_d; otv_q <= otv_d; odv_q <= odv_d;
    olast_q <= olast_d;
  end

endmodule
